[rtl/elevation_grid_interpolated_lookup_assert.svh]
// Assertion macros for the elevation grid lookup.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ELEVATION_GRID_INTERPOLATED_LOOKUP_ASSERT_SVH
`define ELEVATION_GRID_INTERPOLATED_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
`define EGIL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EGIL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EGIL_ASSERT_IMP(lbl, ante, cons)
`define EGIL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/egil_pkg.sv]
// Shared types, constants and exp tables for the elevation grid lookup.
// No dependencies.
package egil_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;

  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_INV_RES   = 3'd2;
  localparam logic [2:0] CFG_ROW_COUNT = 3'd3;
  localparam logic [2:0] CFG_COL_COUNT = 3'd4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic signed [31:0] cell_elevation;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] altitude;
    logic               out_of_bounds;
  } res_t;

  // exp(-k), Q16.16, k = 0..11
  function automatic logic [16:0] exp_int(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd24109;
      4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;
      4'd4:  v = 17'd1200;
      4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;
      4'd7:  v = 17'd60;
      4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-i/32), Q16.16, i = 0..32
  function automatic logic [16:0] exp_frac(input logic [5:0] i);
    logic [16:0] v;
    case (i)
      6'd0:  v = 17'd65536; 6'd1:  v = 17'd63520; 6'd2:  v = 17'd61565;
      6'd3:  v = 17'd59671; 6'd4:  v = 17'd57835; 6'd5:  v = 17'd56056;
      6'd6:  v = 17'd54331; 6'd7:  v = 17'd52660; 6'd8:  v = 17'd51039;
      6'd9:  v = 17'd49469; 6'd10: v = 17'd47947; 6'd11: v = 17'd46472;
      6'd12: v = 17'd45042; 6'd13: v = 17'd43656; 6'd14: v = 17'd42313;
      6'd15: v = 17'd41011; 6'd16: v = 17'd39750; 6'd17: v = 17'd38527;
      6'd18: v = 17'd37341; 6'd19: v = 17'd36192; 6'd20: v = 17'd35079;
      6'd21: v = 17'd34000; 6'd22: v = 17'd32954; 6'd23: v = 17'd31940;
      6'd24: v = 17'd30957; 6'd25: v = 17'd30005; 6'd26: v = 17'd29081;
      6'd27: v = 17'd28187; 6'd28: v = 17'd27319; 6'd29: v = 17'd26479;
      6'd30: v = 17'd25664; 6'd31: v = 17'd24875; 6'd32: v = 17'd24109;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/egil_weight.sv]
// Four-stage pipelined blend weight: exp(-0.5 * d2 * inv_res), floored at 1 LSB.
// Depends on egil_pkg.
module egil_weight import egil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [1:0]  in_tag,
  input  logic [16:0] dc,
  input  logic [16:0] dr,
  input  logic [30:0] inv_res,
  output logic        out_vld,
  output logic [1:0]  out_tag,
  output logic [16:0] weight
);

  logic [3:0]  vld_r;
  logic [1:0]  tag1_r, tag2_r, tag3_r, tag4_r;
  logic [33:0] dc2_r, dr2_r;
  logic [31:0] a_r;
  logic [16:0] t0_r;
  logic [27:0] ip_r;
  logic [3:0]  k_r;
  logic        kok_r;
  logic [16:0] w_r;

  logic [34:0] sq_sum;
  logic [17:0] d2;
  logic [48:0] ad;
  logic [5:0]  fidx;
  logic [16:0] t0, t1, wf;
  logic [33:0] wp;

  always_comb begin
    sq_sum = {1'b0, dc2_r} + {1'b0, dr2_r};
    d2     = sq_sum[33:16];
    ad     = d2 * inv_res;
    fidx   = {1'b0, a_r[15:11]};
    t0     = exp_frac(fidx);
    t1     = exp_frac(fidx + 6'd1);
    wf     = t0_r - 17'(ip_r >> 11);
    wp     = exp_int(k_r) * wf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    tag1_r <= in_tag;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    tag4_r <= tag3_r;
    dc2_r  <= dc * dc;
    dr2_r  <= dr * dr;
    a_r    <= ad[48:17];
    t0_r   <= t0;
    ip_r   <= (t0 - t1) * a_r[10:0];
    k_r    <= a_r[19:16];
    kok_r  <= (a_r[31:16] < 16'd12);
    if (kok_r && (wp[33:16] != '0)) begin
      w_r <= wp[32:16];
    end else begin
      w_r <= 17'd1;
    end
  end

  assign out_vld = vld_r[3];
  assign out_tag = tag4_r;
  assign weight  = w_r;

endmodule

[rtl/elevation_grid_interpolated_lookup.sv]
// Elevation grid lookup: grid RAM, query sequencer, weighted blend and divider.
// Depends on egil_pkg, egil_weight and elevation_grid_interpolated_lookup_assert.svh.
//
//   channel | ports                            | handshake
//   --------+----------------------------------+------------------------------
//   request | start, busy, in_req              | taken when start && !busy
//   result  | out_valid, out_res               | one-cycle strobe, no stall
//   config  | cfg_we, cfg_index, cfg_wdata     | written when cfg_we is high
//
// A write request never raises busy. An in-grid query holds busy through the
// coordinate multiply, the clamp, four RAM reads feeding the weight pipeline,
// multiply-accumulate, a sign prep and the radix-16 divider (four quotient bits a
// cycle); an out-of-bounds query ends after the reads. The result strobe comes with
// the first idle cycle. Reset is synchronous, active low, clears control and config
// only (grid undefined until written); no stalls.
`include "elevation_grid_interpolated_lookup_assert.svh"
module elevation_grid_interpolated_lookup import egil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  output logic        out_valid,
  output res_t        out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_CLAMP = 6'b000100,
    S_FETCH = 6'b001000,
    S_ACC   = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  // config
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [30:0]        inv_res_r;
  logic [8:0]         row_count_r, col_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      inv_res_r   <= 31'd1310720;
      row_count_r <= 9'd256;
      col_count_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:  origin_x_r  <= cfg_wdata;
        CFG_ORIGIN_Y:  origin_y_r  <= cfg_wdata;
        CFG_INV_RES:   inv_res_r   <= cfg_wdata[30:0];
        CFG_ROW_COUNT: row_count_r <= cfg_wdata[8:0];
        CFG_COL_COUNT: col_count_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [2:0] cnt_r;

  logic signed [31:0] qx_r, qy_r;
  logic signed [64:0] px_r, py_r;
  logic [7:0]  rl_r, cl_r, ru_r, cu_r;
  logic [16:0] fc_r, fr_r, dcu_r, dru_r;
  logic        oob_r;

  // grid RAM, one port each way
  logic signed [31:0] grid_mem [MAX_ROWS*MAX_COLS];
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [31:0] rd_q_r;
  logic               rd_vld_r;
  logic [1:0]         rd_idx_r;

  logic signed [31:0] cell_r [4];
  logic [16:0]        w_r [4];

  logic signed [49:0] prod_r;
  logic signed [51:0] sum_r;
  logic               neg_r;
  logic [18:0]        rem_r, tot_r;
  logic [31:0]        q_r;

  logic        out_valid_r;
  res_t        out_res_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (accept && in_req.req_type == REQ_WRITE) begin
      grid_mem[{in_req.cell_row[ROW_W-1:0], in_req.cell_col[COL_W-1:0]}]
        <= in_req.cell_elevation;
    end
    rd_q_r <= grid_mem[rd_addr];
  end

  // sample order: 0 (rl,cl) 1 (ru,cl) 2 (rl,cu) 3 (ru,cu)
  assign rd_addr = {(cnt_r[0] ? ru_r : rl_r), (cnt_r[1] ? cu_r : cl_r)};

  // weight pipeline
  logic        wt_vld;
  logic [1:0]  wt_tag;
  logic [16:0] wt_val;

  egil_weight u_weight (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (state_r == S_FETCH && !cnt_r[2]),
    .in_tag  (cnt_r[1:0]),
    .dc      (cnt_r[1] ? dcu_r : fc_r),
    .dr      (cnt_r[0] ? dru_r : fr_r),
    .inv_res (inv_res_r),
    .out_vld (wt_vld),
    .out_tag (wt_tag),
    .weight  (wt_val)
  );

  // clamp: grid coordinates and bounds
  logic [7:0]  cm1, rm1;
  logic [47:0] gx, gy;
  logic [23:0] cq, rq;
  logic        oob_c;
  always_comb begin
    cm1 = (col_count_r == '0) ? 8'd0 :
          (col_count_r > 9'(MAX_COLS)) ? 8'(MAX_COLS - 1) : 8'(col_count_r - 9'd1);
    rm1 = (row_count_r == '0) ? 8'd0 :
          (row_count_r > 9'(MAX_ROWS)) ? 8'(MAX_ROWS - 1) : 8'(row_count_r - 9'd1);
    gx  = (px_r[64] || px_r == '0) ? '0 : px_r[63:16];
    gy  = (py_r[64] || py_r == '0) ? '0 : py_r[63:16];
    oob_c = (gx == '0) || (gx > {24'd0, cm1, 16'd0}) ||
            (gy == '0) || (gy > {24'd0, rm1, 16'd0});
    cq  = (gx > {24'd0, cm1, 16'd0}) ? {cm1, 16'd0} : gx[23:0];
    rq  = (gy > {24'd0, rm1, 16'd0}) ? {rm1, 16'd0} : gy[23:0];
  end

  // divider: four restoring steps a cycle
  logic [18:0] rem_d;
  logic [31:0] q_d;
  logic [19:0] sh;
  always_comb begin
    rem_d = rem_r;
    q_d   = q_r;
    for (int s = 0; s < 4; s++) begin
      sh  = {rem_d, q_d[31]};
      q_d = {q_d[30:0], 1'b0};
      if (sh >= {1'b0, tot_r}) begin
        rem_d  = 19'(sh - {1'b0, tot_r});
        q_d[0] = 1'b1;
      end else begin
        rem_d = sh[18:0];
      end
    end
  end

  logic [51:0] mag;
  assign mag = sum_r[51] ? 52'(-sum_r) : 52'(sum_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && in_req.req_type == REQ_QUERY) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_FETCH;
      S_FETCH: if (cnt_r == 3'd7) state_nxt = S_ACC;
      S_ACC: begin
        if (oob_r || cnt_r == 3'd5) state_nxt = oob_r ? S_IDLE : S_DIV;
      end
      S_DIV:   if (cnt_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= (state_nxt != state_r) ? 3'd0 : cnt_r + 3'd1;
      rd_vld_r    <= (state_r == S_FETCH) && !cnt_r[2];
      out_valid_r <= ((state_r == S_ACC) && oob_r) ||
                     ((state_r == S_DIV) && cnt_r == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[1:0];
    if (accept) begin
      qx_r <= in_req.query_x;
      qy_r <= in_req.query_y;
    end
    px_r <= ($signed({qx_r[31], qx_r}) - $signed({origin_x_r[31], origin_x_r}))
            * $signed({1'b0, inv_res_r});
    py_r <= ($signed({qy_r[31], qy_r}) - $signed({origin_y_r[31], origin_y_r}))
            * $signed({1'b0, inv_res_r});
    if (state_r == S_CLAMP) begin
      oob_r <= oob_c;
      cl_r  <= cq[23:16];
      rl_r  <= rq[23:16];
      cu_r  <= (cq[23:16] < cm1) ? cq[23:16] + 8'd1 : cm1;
      ru_r  <= (rq[23:16] < rm1) ? rq[23:16] + 8'd1 : rm1;
      fc_r  <= {1'b0, cq[15:0]};
      fr_r  <= {1'b0, rq[15:0]};
      // upper neighbor clamped onto the lower one: distance stays the fraction
      dcu_r <= (cq[23:16] < cm1) ? 17'h10000 - {1'b0, cq[15:0]} : {1'b0, cq[15:0]};
      dru_r <= (rq[23:16] < rm1) ? 17'h10000 - {1'b0, rq[15:0]} : {1'b0, rq[15:0]};
      sum_r <= '0;
    end
    if (rd_vld_r) cell_r[rd_idx_r] <= rd_q_r;
    if (wt_vld)   w_r[wt_tag]      <= wt_val;
    if (state_r == S_ACC) begin
      if (!cnt_r[2]) prod_r <= $signed({1'b0, w_r[cnt_r[1:0]]}) * cell_r[cnt_r[1:0]];
      if (cnt_r != 3'd0 && cnt_r != 3'd5) sum_r <= sum_r + 52'(prod_r);
      if (cnt_r == 3'd5) begin
        neg_r <= sum_r[51];
        rem_r <= mag[50:32];
        q_r   <= mag[31:0];
        tot_r <= 19'(w_r[0]) + 19'(w_r[1]) + 19'(w_r[2]) + 19'(w_r[3]);
      end
      if (oob_r) begin
        out_res_r.altitude      <= cell_r[0];
        out_res_r.out_of_bounds <= 1'b1;
      end
    end
    if (state_r == S_DIV) begin
      rem_r <= rem_d;
      q_r   <= q_d;
      if (cnt_r == 3'd7) begin
        out_res_r.altitude      <= neg_r ? -q_d : q_d;
        out_res_r.out_of_bounds <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a cell write never produces a result
  `EGIL_ASSERT_NXT(a_write_silent, start && !busy && in_req.req_type == REQ_WRITE, !out_valid)
  // one result per query: strobes never come back to back
  `EGIL_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  // an accepted query holds the request side off
  `EGIL_ASSERT_NXT(a_query_busy, start && !busy && in_req.req_type == REQ_QUERY, busy)
  // a result is only produced by a query in flight
  `EGIL_ASSERT_IMP(a_result_from_query, out_valid, $past(busy))

endmodule
